// File: rtl/core/pfbm_pkg.sv
// Shared types and constants for the page frame bitmap manager.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pfbm_pkg;

  // Store geometry
  localparam int BITMAP_WORDS = 32768;
  localparam int WORD_BITS    = 32;
  localparam int FRAME_SHIFT  = 12;

  localparam int ADDR_W     = 32;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int FRAME_W    = ADDR_W - FRAME_SHIFT;     // frame number bits
  localparam int LAST_W     = FRAME_W + 1;              // can hold 2^FRAME_W
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_IDX_W = $clog2(BITMAP_WORDS);
  localparam int SUM_W      = ADDR_W + 1;

  localparam int STORE_FRAMES_I = BITMAP_WORDS * WORD_BITS;
  localparam int SPACE_FRAMES_I = 1 << FRAME_W;
  localparam int SEARCH_WORDS   = (BITMAP_WORDS < SPACE_FRAMES_I / WORD_BITS) ?
                                  BITMAP_WORDS : SPACE_FRAMES_I / WORD_BITS;

  localparam logic [LAST_W-1:0]     STORE_FRAMES = LAST_W'(STORE_FRAMES_I);
  localparam logic [LAST_W-1:0]     SPACE_FRAMES = LAST_W'(SPACE_FRAMES_I);
  localparam logic [WORD_IDX_W-1:0] SEARCH_LAST  = WORD_IDX_W'(SEARCH_WORDS - 1);
  localparam logic [WORD_IDX_W-1:0] STORE_LAST   = WORD_IDX_W'(BITMAP_WORDS - 1);

  // Beat layout
  localparam int IN_DATA_W  = 72;  // 3 + 32 + 32 = 67, padded to bytes
  localparam int OUT_DATA_W = 24;  // 1 + 20 + 2 = 23, padded to bytes

  // Request codes
  localparam logic [REQ_W-1:0] REQ_SET       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TEST      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET_RNG   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR_RNG = 3'd4;
  localparam logic [REQ_W-1:0] REQ_FIND_SET  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_FIND_CLR  = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_READ,
    S_MOD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/pfbm_word_unit.sv
// Shared word datapath: bit-range mask, read-modify-write value, bit pick
// and lowest-match search within one bitmap word. Depends on pfbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfbm_word_unit import pfbm_pkg::*; (
  input  wire logic [WORD_BITS-1:0] data,
  input  wire logic [BIT_W-1:0]     lo,
  input  wire logic [BIT_W-1:0]     hi,
  input  wire logic                 set_val,
  input  wire logic                 want,
  output logic [WORD_BITS-1:0]      wdata,
  output logic                      bit_sel,
  output logic                      hit,
  output logic [BIT_W-1:0]          idx
);

  localparam logic [WORD_BITS-1:0] ONES = '1;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] iso;

  // Mask of bits lo..hi inclusive
  always_comb begin
    mask  = (ONES << lo) & (ONES >> (BIT_W'(WORD_BITS - 1) - hi));
    wdata = set_val ? (data | mask) : (data & ~mask);
  end

  assign bit_sel = data[lo];

  // Word holds a wanted bit unless it is all-skip
  assign hit = want ? (|data) : ~(&data);

  // Lowest wanted bit: isolate it, then encode its position
  always_comb begin
    cand = want ? data : ~data;
    iso  = cand & (~cand + WORD_BITS'(1));
    idx  = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/page_frame_bitmap_manager.sv
// Top level: stream ports, request sequencer and the bitmap store.
// Depends on pfbm_pkg and pfbm_word_unit.
//
//  port group | dir | payload (lsb first)                         | beat
//  -----------+-----+---------------------------------------------+----------
//  s_*        | in  | req_type[2:0] address[34:3] range_size[66:35]| request
//  m_*        | out | bit_value[0] found_frame[20:1] status[22:21] | result
//
// Single-frame requests pass through read, modify/write and result. A range
// visits each bitmap word it touches after a clip step, a search each word
// scanned; with a one-port store each word takes a read then a modify state.
// After reset a clearing pass writes zero to all 32768 words, one a cycle,
// before s_tready rises. A stalled result sits in the output register while
// the next request is taken; a request finishing behind it waits.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_bitmap_manager import pfbm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // req_type, address, range_size
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata   // bit_value, found_frame, status
);

  // Request fields
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] range_size;
  assign req_type   = s_tdata[REQ_W-1:0];
  assign address    = s_tdata[REQ_W +: ADDR_W];
  assign range_size = s_tdata[REQ_W + ADDR_W +: ADDR_W];

  // Sequencer registers
  state_t                state, state_next;
  logic [REQ_W-1:0]      op, op_next;
  logic [FRAME_W-1:0]    frame, frame_next;
  logic [SUM_W-1:0]      end_sum, end_sum_next;
  logic [WORD_IDX_W-1:0] cur_word, cur_word_next;
  logic [WORD_IDX_W-1:0] end_word, end_word_next;
  logic [BIT_W-1:0]      first_bit, first_bit_next;
  logic [BIT_W-1:0]      last_bit, last_bit_next;
  logic                  res_bit, res_bit_next;
  logic [FRAME_W-1:0]    res_found, res_found_next;
  logic [STATUS_W-1:0]   res_status, res_status_next;

  // Store
  logic [WORD_BITS-1:0]  mem [BITMAP_WORDS];
  logic [WORD_BITS-1:0]  rd_data;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic                  mem_we;
  logic                  mem_re;

  // Word unit hookup
  logic [BIT_W-1:0]      u_lo, u_hi, u_idx;
  logic [WORD_BITS-1:0]  u_wdata;
  logic                  u_bit, u_hit, u_set, u_want;

  // Range end helpers
  logic [LAST_W-1:0]     last_raw, last_c, last_m1;
  logic                  over;
  logic                  out_free;

  logic [FRAME_W-1:0]    in_frame;
  assign in_frame = address[ADDR_W-1:FRAME_SHIFT];

  assign out_free = ~m_tvalid | m_tready;
  assign s_tready = (state == S_IDLE);

  pfbm_word_unit u_word (
    .data    (rd_data),
    .lo      (u_lo),
    .hi      (u_hi),
    .set_val (u_set),
    .want    (u_want),
    .wdata   (u_wdata),
    .bit_sel (u_bit),
    .hit     (u_hit),
    .idx     (u_idx)
  );

  assign u_set  = (op == REQ_SET) || (op == REQ_SET_RNG);
  assign u_want = (op == REQ_FIND_SET);

  // Bit bounds within the current word
  always_comb begin
    case (op) inside
      REQ_SET_RNG, REQ_CLEAR_RNG: begin
        u_lo = (cur_word == frame[BIT_W +: WORD_IDX_W]) ? first_bit : '0;
        u_hi = (cur_word == end_word) ? last_bit : '1;
      end
      default: begin
        u_lo = first_bit;
        u_hi = last_bit;
      end
    endcase
  end

  // Saturated, store-clipped range end
  always_comb begin
    last_raw = end_sum[ADDR_W] ? SPACE_FRAMES : LAST_W'(end_sum[ADDR_W-1:FRAME_SHIFT]);
    over     = last_raw > STORE_FRAMES;
    last_c   = over ? STORE_FRAMES : last_raw;
    last_m1  = last_c - LAST_W'(1);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cur_word <= '0;
    end else begin
      state    <= state_next;
      cur_word <= cur_word_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    frame      <= frame_next;
    end_sum    <= end_sum_next;
    end_word   <= end_word_next;
    first_bit  <= first_bit_next;
    last_bit   <= last_bit_next;
    res_bit    <= res_bit_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
  end

  // Next state and controls
  always_comb begin
    state_next      = state;
    op_next         = op;
    frame_next      = frame;
    end_sum_next    = end_sum;
    cur_word_next   = cur_word;
    end_word_next   = end_word;
    first_bit_next  = first_bit;
    last_bit_next   = last_bit;
    res_bit_next    = res_bit;
    res_found_next  = res_found;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_wdata       = u_wdata;

    case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_wdata     = '0;
        cur_word_next = cur_word + WORD_IDX_W'(1);
        if (cur_word == STORE_LAST) begin
          cur_word_next = '0;
          state_next    = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_tvalid) begin
          op_next         = req_type;
          frame_next      = in_frame;
          end_sum_next    = {1'b0, address} + {1'b0, range_size};
          res_bit_next    = 1'b0;
          res_found_next  = '0;
          res_status_next = ST_OK;
          first_bit_next  = in_frame[BIT_W-1:0];
          last_bit_next   = in_frame[BIT_W-1:0];
          cur_word_next   = in_frame[BIT_W +: WORD_IDX_W];
          case (req_type) inside
            REQ_SET, REQ_CLEAR, REQ_TEST: begin
              if ({1'b0, in_frame} >= STORE_FRAMES) begin
                res_status_next = ST_RANGE;
                state_next      = S_DONE;
              end else begin
                state_next = S_READ;
              end
            end
            REQ_SET_RNG, REQ_CLEAR_RNG: begin
              if ((address[FRAME_SHIFT-1:0] != '0) ||
                  (range_size[FRAME_SHIFT-1:0] != '0)) begin
                res_status_next = ST_MISALIGN;
                state_next      = S_DONE;
              end else begin
                state_next = S_PREP;
              end
            end
            REQ_FIND_SET, REQ_FIND_CLR: begin
              cur_word_next = '0;
              state_next    = S_READ;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Clip the range and set up the word walk
      S_PREP: begin
        if (over && (last_raw > {1'b0, frame})) begin
          res_status_next = ST_RANGE;
        end
        if ({1'b0, frame} >= last_c) begin
          state_next = S_DONE;
        end else begin
          end_word_next = last_m1[BIT_W +: WORD_IDX_W];
          last_bit_next = last_m1[BIT_W-1:0];
          state_next    = S_READ;
        end
      end

      S_READ: begin
        mem_re     = 1'b1;
        state_next = S_MOD;
      end

      S_MOD: begin
        case (op) inside
          REQ_TEST: begin
            res_bit_next = u_bit;
            state_next   = S_DONE;
          end
          REQ_SET, REQ_CLEAR: begin
            mem_we     = 1'b1;
            state_next = S_DONE;
          end
          REQ_SET_RNG, REQ_CLEAR_RNG: begin
            mem_we = 1'b1;
            if (cur_word == end_word) begin
              state_next = S_DONE;
            end else begin
              cur_word_next = cur_word + WORD_IDX_W'(1);
              state_next    = S_READ;
            end
          end
          default: begin
            // searches
            if (u_hit) begin
              res_found_next = FRAME_W'({cur_word, u_idx});
              state_next     = S_DONE;
            end else if (cur_word == SEARCH_LAST) begin
              res_status_next = ST_NOT_FOUND;
              state_next      = S_DONE;
            end else begin
              cur_word_next = cur_word + WORD_IDX_W'(1);
              state_next    = S_READ;
            end
          end
        endcase
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Bitmap store, one address per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_word] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[cur_word];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= OUT_DATA_W'({res_status, res_found, res_bit});
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pfbm_checker.sv
// Port-level checks for page_frame_bitmap_manager, bound to the top level.
// Depends on pfbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfbm_checker import pfbm_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed under stall");

  // One request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // Failed search reports frame zero
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[22:21] == ST_NOT_FOUND) |-> (m_tdata[20:1] == '0))
    else $error("not-found result carries a frame");

  // A set test bit only comes with ok status
  a_bit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[22:21] == ST_OK) && (m_tdata[20:1] == '0))
    else $error("test bit with bad status or frame");

endmodule

bind page_frame_bitmap_manager pfbm_checker u_pfbm_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for page_frame_bitmap_manager: request beats in, result beats out.
// It keeps its own copy of the frame bitmap, predicts each result and compares it field by field.
// Depends on pfbm_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;
  import pfbm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int SEARCH_CAP = 256;   // random searches past this many words get swapped out
  localparam int WINDOW_FRAMES = 1024;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  found_frame;
    logic                bit_value;
  } frame_result_t;

  typedef struct {
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] range_size;
    frame_result_t     outcome;
    bit                wait_idle;
  } bitmap_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow copy of the bitmap store, all frames free after reset
  bit [WORD_BITS-1:0] frame_map [BITMAP_WORDS];

  bitmap_request_t pending_requests[$];
  bitmap_request_t expected_results[$];
  bitmap_request_t cur_req;

  bit     s_taken = 1'b0;
  bit     send_calm = 1'b0;
  bit     recv_calm = 1'b0;
  int     idle_left = 0;
  int     stall_left = 0;
  int     mismatch_count = 0;
  int     result_count = 0;
  longint cycle_count = 0;
  longint cycle_budget = 0;
  longint cycle_limit = 64'd100_000_000;

  page_frame_bitmap_manager uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Lowest frame holding the wanted value; scanned counts words visited
  function automatic void find_lowest(input bit want, output logic [STATUS_W-1:0] st,
                                      output logic [FRAME_W-1:0] hit, output int scanned);
    longint limit;
    longint base;
    bit [WORD_BITS-1:0] skip;
    limit = (SPACE_FRAMES_I < STORE_FRAMES_I) ? SPACE_FRAMES_I : STORE_FRAMES_I;
    skip = want ? '0 : '1;
    st = ST_NOT_FOUND;
    hit = '0;
    scanned = 0;
    for (int w = 0; w < BITMAP_WORDS; w++) begin
      base = longint'(w) * WORD_BITS;
      if (base >= limit) break;
      scanned++;
      if (frame_map[w] == skip) continue;
      for (int b = 0; b < WORD_BITS && base + b < limit; b++) begin
        if (frame_map[w][b] == want) begin
          hit = FRAME_W'(base + b);
          st = ST_OK;
          return;
        end
      end
    end
  endfunction

  // Apply one request to the shadow bitmap; touched is the number of store words involved
  function automatic frame_result_t apply_request(input logic [REQ_W-1:0] req,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [ADDR_W-1:0] size,
                                                  output int touched);
    frame_result_t r;
    longint frame, last, stop, f;
    logic [STATUS_W-1:0] st;
    logic [FRAME_W-1:0] hit;
    r = '0;
    touched = 1;
    frame = addr >> FRAME_SHIFT;
    case (req)
      REQ_SET, REQ_CLEAR, REQ_TEST: begin
        if (frame >= STORE_FRAMES_I) begin
          r.status = ST_RANGE;
        end else if (req == REQ_TEST) begin
          r.bit_value = frame_map[frame / WORD_BITS][frame % WORD_BITS];
        end else begin
          frame_map[frame / WORD_BITS][frame % WORD_BITS] = (req == REQ_SET);
        end
      end
      REQ_SET_RNG, REQ_CLEAR_RNG: begin
        if (addr[FRAME_SHIFT-1:0] != 0 || size[FRAME_SHIFT-1:0] != 0) begin
          r.status = ST_MISALIGN;
        end else begin
          stop = addr;
          stop += size;
          // saturate at the top of the address space
          if (stop > (longint'(1) << ADDR_W)) stop = longint'(1) << ADDR_W;
          last = stop >> FRAME_SHIFT;
          if (last > STORE_FRAMES_I) begin
            if (last > frame) r.status = ST_RANGE;
            last = STORE_FRAMES_I;
          end
          touched = (last > frame) ? int'((last - 1) / WORD_BITS - frame / WORD_BITS + 1) : 0;
          for (f = frame; f < last; f++)
            frame_map[f / WORD_BITS][f % WORD_BITS] = (req == REQ_SET_RNG);
        end
      end
      REQ_FIND_SET, REQ_FIND_CLR: begin
        find_lowest(req == REQ_FIND_SET, st, hit, touched);
        r.status = st;
        r.found_frame = hit;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Byte address inside the low frame window, random offset within the page
  function automatic logic [ADDR_W-1:0] window_addr();
    return (ADDR_W'($urandom_range(0, WINDOW_FRAMES - 1)) << FRAME_SHIFT) |
           ($urandom & ((32'd1 << FRAME_SHIFT) - 1));
  endfunction

  task automatic queue_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                               input logic [ADDR_W-1:0] size, input bit wait_idle);
    bitmap_request_t r;
    int touched;
    r.req_type = req;
    r.address = addr;
    r.range_size = size;
    r.wait_idle = wait_idle;
    r.outcome = apply_request(req, addr, size, touched);
    cycle_budget += 2 * touched + 140;
    pending_requests.push_back(r);
  endtask

  // Stimulus: directed corners, then random traffic around a low frame window
  initial begin
    int roll;
    bit want;
    int scanned;
    logic [STATUS_W-1:0] st;
    logic [FRAME_W-1:0] hit;
    logic [ADDR_W-1:0] page_mask;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] sz;
    page_mask = (32'd1 << FRAME_SHIFT) - 1;

    // empty store: search for set fails, search for clear hits frame 0
    queue_request(REQ_FIND_SET, 32'h0, 32'h0, 1'b0);
    queue_request(REQ_FIND_CLR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_request(REQ_TEST, 32'h0, 32'h0, 1'b0);
    queue_request(REQ_SET, 32'h0000_0FFF, 32'h0, 1'b0);
    queue_request(REQ_TEST, 32'h0, 32'h0, 1'b0);
    queue_request(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_request(REQ_TEST, 32'hFFFF_F000, 32'h0, 1'b0);
    queue_request(REQ_FIND_SET, 32'h0, 32'h0, 1'b0);
    queue_request(REQ_FIND_CLR, 32'h0, 32'h0, 1'b0);
    queue_request(REQ_CLEAR, 32'h0000_0123, 32'h0, 1'b0);
    queue_request(REQ_FIND_SET, 32'h0, 32'h0, 1'b0);        // only the top frame is set
    queue_request(REQ_CLEAR, 32'hFFFF_FABC, 32'h0, 1'b0);
    // misaligned start, misaligned size, empty range, unused code
    queue_request(REQ_SET_RNG, 32'h0000_1001, 32'h0000_1000, 1'b1);
    queue_request(REQ_CLEAR_RNG, 32'h0, 32'h0000_0800, 1'b0);
    queue_request(REQ_SET_RNG, 32'h0000_5000, 32'h0, 1'b0);
    queue_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // range running past the top saturates
    queue_request(REQ_SET_RNG, 32'hFFFF_E000, 32'hFFFF_F000, 1'b0);
    queue_request(REQ_FIND_SET, 32'h0, 32'h0, 1'b0);
    queue_request(REQ_CLEAR_RNG, 32'hFFFF_E000, 32'h0000_2000, 1'b0);
    // fill the whole store, then search for clear fails
    queue_request(REQ_SET_RNG, 32'h0, 32'hFFFF_F000, 1'b0);
    queue_request(REQ_FIND_CLR, 32'h0, 32'h0, 1'b0);
    queue_request(REQ_SET, 32'hFFFF_F000, 32'h0, 1'b0);
    queue_request(REQ_FIND_CLR, 32'h0, 32'h0, 1'b0);
    queue_request(REQ_CLEAR_RNG, 32'h0, 32'hFFFF_F000, 1'b0);
    queue_request(REQ_CLEAR, 32'hFFFF_F000, 32'h0, 1'b0);
    // range crossing a word boundary
    queue_request(REQ_SET_RNG, 32'h0001_F000, 32'h0000_3000, 1'b0);
    queue_request(REQ_TEST, 32'h0002_1000, 32'h0, 1'b0);
    queue_request(REQ_FIND_SET, 32'h0, 32'h0, 1'b0);

    for (int n = 0; n < 700; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        a = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom) : window_addr();
        queue_request(roll < 12 ? REQ_SET : roll < 24 ? REQ_CLEAR : REQ_TEST, a, $urandom,
                      n % 150 == 149);
      end else if (roll < 68) begin
        if (roll < 52) begin
          a = ADDR_W'($urandom_range(0, WINDOW_FRAMES - 1)) << FRAME_SHIFT;
          sz = ADDR_W'($urandom_range(0, 70)) << FRAME_SHIFT;
        end else if (roll < 57) begin
          a = ADDR_W'($urandom_range(0, 8191)) << FRAME_SHIFT;
          sz = ADDR_W'($urandom_range(0, 4096)) << FRAME_SHIFT;
        end else if (roll < 59) begin
          // start near the top with a large size: the end saturates
          a = ADDR_W'(SPACE_FRAMES_I - 1 - $urandom_range(0, 100)) << FRAME_SHIFT;
          sz = $urandom & ~page_mask;
        end else begin
          a = $urandom;
          sz = $urandom;
          if ((a & page_mask) == 0 && (sz & page_mask) == 0) a[0] = 1'b1;
        end
        queue_request($urandom_range(0, 1) ? REQ_SET_RNG : REQ_CLEAR_RNG, a, sz,
                      n % 150 == 149);
      end else if (roll < 97) begin
        // long scans are swapped for a write that makes the next search short
        want = $urandom_range(0, 1);
        find_lowest(want, st, hit, scanned);
        if (scanned > SEARCH_CAP)
          queue_request(want ? REQ_SET : REQ_CLEAR, window_addr(), $urandom, n % 150 == 149);
        else
          queue_request(want ? REQ_FIND_SET : REQ_FIND_CLR, $urandom, $urandom,
                        n % 150 == 149);
      end else begin
        queue_request(REQ_UNUSED, $urandom, $urandom, n % 150 == 149);
      end
    end
    cycle_limit = 4 * cycle_budget + 4 * (BITMAP_WORDS + 100);

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Request driver: one beat at a time, random gaps after each accepted beat
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      if (s_taken) idle_left = pick_gap(send_calm);
      if (!s_tvalid || s_taken) begin
        if (idle_left > 0) begin
          idle_left--;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0 &&
                     (!pending_requests[0].wait_idle || expected_results.size() == 0)) begin
          cur_req = pending_requests.pop_front();
          s_tdata <= IN_DATA_W'({cur_req.range_size, cur_req.address, cur_req.req_type});
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (stall_left == 0 && !recv_calm && $urandom_range(0, 3) == 0)
        stall_left = pick_gap(1'b0);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: check result beats in order, record expectation of each accepted request
  always @(posedge clk) begin
    frame_result_t got;
    bitmap_request_t exp_req;
    if (rst) begin
      s_taken <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      s_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(frame_result_t)-1:0];
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("result %0d: beat %h with no request outstanding", result_count, m_tdata);
          mismatch_count++;
        end else begin
          exp_req = expected_results.pop_front();
          if (got.bit_value !== exp_req.outcome.bit_value ||
              got.found_frame !== exp_req.outcome.found_frame ||
              got.status !== exp_req.outcome.status) begin
            if (mismatch_count < 10)
              $display({"result %0d (req %0d addr %h size %h): ",
                        "expected bit %0d frame %h st %0d, got bit %0d frame %h st %0d"},
                       result_count, exp_req.req_type, exp_req.address, exp_req.range_size,
                       exp_req.outcome.bit_value, exp_req.outcome.found_frame,
                       exp_req.outcome.status, got.bit_value, got.found_frame, got.status);
            mismatch_count++;
          end
        end
        result_count++;
      end
      if (s_tvalid && s_tready) expected_results.push_back(cur_req);
    end
  end

endmodule
